// File: hdl/brhp_pkg.sv
// ----------------------------------------------------------------------------
// Byte range header parser - shared definitions
// Field widths, character codes, parser phases and byte classifiers used by
// the core and its range unit.
// ----------------------------------------------------------------------------
package brhp_pkg;

   // fixed field widths
   localparam int FILE_SIZE_BITS  = 48;
   localparam int SUM_BITS        = 51;
   localparam int RANGE_NUM_BITS  = 3;
   localparam int FOUND_BITS      = 4;
   localparam int BYTE_BITS       = 8;
   localparam int RSP_DATA_BITS   = 160;

   // parameter defaults
   localparam int DEFAULT_MAX_RANGE_COUNT = 8;
   localparam int DEFAULT_OFFSET_BITS     = 48;

   // character codes
   localparam logic [BYTE_BITS-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_BITS-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_BITS-1:0] CHAR_NINE  = 8'h39;

   // parser phase, one-hot
   typedef enum logic [7:0] {
      PHASE_START  = 8'b0000_0001,
      PHASE_LEAD   = 8'b0000_0010,
      PHASE_FIRST  = 8'b0000_0100,
      PHASE_SUFFIX = 8'b0000_1000,
      PHASE_SECOND = 8'b0001_0000,
      PHASE_TRAIL  = 8'b0010_0000,
      PHASE_CR     = 8'b0100_0000,
      PHASE_DONE   = 8'b1000_0000
   } phase_type;

   function automatic logic is_digit(input logic [BYTE_BITS-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_blank(input logic [BYTE_BITS-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

endpackage

// File: hdl/brhp_range_calc.sv
// ----------------------------------------------------------------------------
// Byte range header parser - range completion unit
// Checks a parsed range against the file size, forms its start and exclusive
// end, and adds its length to the running total with saturation.
// ----------------------------------------------------------------------------
module brhp_range_calc #(
   parameter int OFFSET_BITS = brhp_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic                                is_suffix,
   input  logic                                has_second,
   input  logic [OFFSET_BITS-1:0]              first_num,
   input  logic [OFFSET_BITS-1:0]              second_num,
   input  logic [brhp_pkg::FILE_SIZE_BITS-1:0] file_size,
   input  logic [brhp_pkg::SUM_BITS-1:0]       sum_cur,
   output logic                                range_ok,
   output logic [brhp_pkg::FILE_SIZE_BITS-1:0] range_start,
   output logic [brhp_pkg::FILE_SIZE_BITS-1:0] range_end,
   output logic [brhp_pkg::SUM_BITS-1:0]       sum_next
);
   import brhp_pkg::*;

   localparam int CMP_BITS = (OFFSET_BITS > FILE_SIZE_BITS) ? OFFSET_BITS : FILE_SIZE_BITS;
   localparam int ADD_BITS = ((CMP_BITS > SUM_BITS) ? CMP_BITS : SUM_BITS) + 1;
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   logic [CMP_BITS-1:0] fs_ext;
   logic [CMP_BITS-1:0] a_ext;
   logic [CMP_BITS-1:0] b_ext;
   logic [CMP_BITS-1:0] s_val;
   logic [CMP_BITS-1:0] e_val;
   logic [CMP_BITS-1:0] len_val;
   logic [ADD_BITS-1:0] total;

   assign fs_ext = CMP_BITS'(file_size);
   assign a_ext  = CMP_BITS'(first_num);
   assign b_ext  = CMP_BITS'(second_num);

   // bounds check and offsets
   always_comb begin
      if (is_suffix) begin
         range_ok = has_second && (b_ext <= fs_ext);
         s_val    = fs_ext - b_ext;
         e_val    = fs_ext;
      end else begin
         range_ok = (a_ext < fs_ext) && (!has_second || ((b_ext <= fs_ext) && (a_ext < b_ext)));
         s_val    = a_ext;
         e_val    = has_second ? b_ext : fs_ext;
      end
   end

   // saturating running total
   assign len_val  = e_val - s_val;
   assign total    = ADD_BITS'(sum_cur) + ADD_BITS'(len_val);
   assign sum_next = (total > ADD_BITS'(SUM_MAX)) ? SUM_MAX : SUM_BITS'(total);

   assign range_start = FILE_SIZE_BITS'(s_val);
   assign range_end   = FILE_SIZE_BITS'(e_val);

endmodule

// File: hdl/byte_range_header_parser_core.sv
// A req word goes to the input register, then the result register. Throughput: one
// byte per cycle unless rsp stalls; the parse of each byte is a single pass from the
// input register to the result register, with the decimal accumulate and range check.
// Reset (synchronous, active high) empties both registers, returns the parser to the
// start of the first range and clears file_size to zero.
// ----------------------------------------------------------------------------
// Byte range header parser - core
// Parses the bytes of a Range value after "bytes=" into ranges checked against the
// file size, with a running total and a final status word on the last byte.
// ----------------------------------------------------------------------------
module byte_range_header_parser_core #(
   parameter int MAX_RANGE_COUNT = brhp_pkg::DEFAULT_MAX_RANGE_COUNT,
   parameter int OFFSET_BITS     = brhp_pkg::DEFAULT_OFFSET_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [brhp_pkg::BYTE_BITS-1:0]      req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // last_byte
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [47:0] range_start, [95:48] range_end, [98:96] range_number,
   // [149:99] total_length, [153:150] ranges_found, [154] parse_error, rest zero
   output logic [brhp_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast,   // final_result
   // configuration
   input  logic                                csr_wr_en,
   input  logic [brhp_pkg::FILE_SIZE_BITS-1:0] csr_wr_data  // file_size
);
   import brhp_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_RANGE_COUNT + 1);
   localparam int ACC_BITS = OFFSET_BITS + 4;
   localparam int PAD_BITS = RSP_DATA_BITS - (2 * FILE_SIZE_BITS + RANGE_NUM_BITS + SUM_BITS
                                              + FOUND_BITS + 1);

   // configuration register
   logic [FILE_SIZE_BITS-1:0] file_size_ff;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0] in_byte_ff;
   logic                 in_last_ff;

   // result register
   logic                     out_valid_ff, out_valid_in;
   logic [RSP_DATA_BITS-1:0] out_data_ff, out_data_in;
   logic                     out_last_ff;

   // parser state
   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] first_ff, first_in;
   logic [OFFSET_BITS-1:0] second_ff, second_in;
   logic [1:0]             dseen_ff, dseen_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                   err_ff, err_in;

   // handshake
   logic req_accept;
   logic advance;
   logic emit;

   // byte classification and decimal accumulate
   logic                   c_digit, c_blank, c_term;
   logic [3:0]             dval;
   logic [OFFSET_BITS-1:0] acc_src;
   logic [ACC_BITS-1:0]    acc_wide;
   logic                   acc_ovf;
   logic [OFFSET_BITS-1:0] acc_val;

   // state after the byte itself
   phase_type              ph_mid;
   logic [OFFSET_BITS-1:0] first_mid, second_mid;
   logic [1:0]             dseen_mid;
   logic                   err_mid;
   logic                   term_fire;

   // range completion
   logic                      do_complete;
   logic                      range_ok;
   logic [FILE_SIZE_BITS-1:0] range_start, range_end;
   logic [SUM_BITS-1:0]       sum_next;
   logic                      got;
   logic                      end_byte;

   // state after completion and terminator
   phase_type              ph_c;
   logic [OFFSET_BITS-1:0] first_c, second_c;
   logic [1:0]             dseen_c;
   logic [CNT_BITS-1:0]    count_c;
   logic [SUM_BITS-1:0]    sum_c;
   logic                   err_c;

   // handshake control
   assign req_accept = req_tvalid && req_tready;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? emit : (rsp_tready ? 1'b0 : out_valid_ff);

   // byte classes and accumulate into the active number
   assign c_digit  = is_digit(in_byte_ff);
   assign c_blank  = is_blank(in_byte_ff);
   assign c_term   = c_blank || (in_byte_ff == CHAR_COMMA) || (in_byte_ff == CHAR_CR);
   assign dval     = in_byte_ff[3:0];
   assign acc_src  = (phase_ff == PHASE_FIRST) ? first_ff : second_ff;
   assign acc_wide = (ACC_BITS'(acc_src) << 3) + (ACC_BITS'(acc_src) << 1) + ACC_BITS'(dval);
   assign acc_ovf  = |acc_wide[ACC_BITS-1:OFFSET_BITS];
   assign acc_val  = acc_wide[OFFSET_BITS-1:0];

   // per-phase handling of the byte
   always_comb begin
      ph_mid     = phase_ff;
      first_mid  = first_ff;
      second_mid = second_ff;
      dseen_mid  = dseen_ff;
      err_mid    = err_ff;
      term_fire  = 1'b0;
      if (!err_ff) begin
         case (phase_ff)
            PHASE_START, PHASE_LEAD: begin
               if (c_blank && (phase_ff == PHASE_LEAD)) begin
                  ph_mid = phase_ff;
               end else if (c_digit) begin
                  first_mid = OFFSET_BITS'(dval);
                  dseen_mid = 2'b01;
                  ph_mid    = PHASE_FIRST;
               end else if (in_byte_ff == CHAR_DASH) begin
                  second_mid = '0;
                  dseen_mid  = 2'b00;
                  ph_mid     = PHASE_SUFFIX;
               end else begin
                  err_mid = 1'b1;
               end
            end
            PHASE_FIRST: begin
               if (c_digit) begin
                  if (acc_ovf) err_mid = 1'b1;
                  else first_mid = acc_val;
               end else if (in_byte_ff == CHAR_DASH) begin
                  second_mid = '0;
                  ph_mid     = PHASE_SECOND;
               end else begin
                  err_mid = 1'b1;
               end
            end
            PHASE_SUFFIX, PHASE_SECOND: begin
               if (c_digit) begin
                  if (acc_ovf) err_mid = 1'b1;
                  else second_mid = acc_val;
                  dseen_mid = dseen_ff | 2'b10;
               end else if (c_term) begin
                  term_fire = 1'b1;
               end else begin
                  err_mid = 1'b1;
               end
            end
            PHASE_TRAIL: begin
               ph_mid = phase_ff;    // handled with the terminator below
            end
            PHASE_CR: begin
               if (in_byte_ff == CHAR_LF) ph_mid = PHASE_DONE;
               else err_mid = 1'b1;
            end
            default: begin
               err_mid = 1'b1;
            end
         endcase
      end
   end

   // a range completes on a terminator, or on the last byte inside a range
   assign do_complete = !err_mid && (term_fire || (in_last_ff &&
                        (ph_mid inside {PHASE_SUFFIX, PHASE_SECOND})));

   brhp_range_calc #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_range_calc (
      .is_suffix   (ph_mid == PHASE_SUFFIX),
      .has_second  (dseen_mid[1]),
      .first_num   (first_mid),
      .second_num  (second_mid),
      .file_size   (file_size_ff),
      .sum_cur     (sum_ff),
      .range_ok    (range_ok),
      .range_start (range_start),
      .range_end   (range_end),
      .sum_next    (sum_next)
   );

   // completion, terminator and end-of-value checks
   always_comb begin
      ph_c     = ph_mid;
      first_c  = first_mid;
      second_c = second_mid;
      dseen_c  = dseen_mid;
      count_c  = count_ff;
      sum_c    = sum_ff;
      err_c    = err_mid;
      got      = 1'b0;
      if (do_complete) begin
         if (range_ok) begin
            got     = 1'b1;
            count_c = count_ff + 1'b1;
            sum_c   = sum_next;
            ph_c    = PHASE_TRAIL;
         end else begin
            err_c = 1'b1;
         end
      end
      end_byte = !err_c && (((phase_ff == PHASE_TRAIL) && !err_ff) || (term_fire && got));
      if (end_byte) begin
         if (c_blank) begin
            ph_c = PHASE_TRAIL;
         end else if (in_byte_ff == CHAR_COMMA) begin
            if (count_c >= CNT_BITS'(MAX_RANGE_COUNT)) begin
               err_c = 1'b1;
            end else begin
               ph_c     = PHASE_LEAD;
               first_c  = '0;
               second_c = '0;
               dseen_c  = 2'b00;
            end
         end else if (in_byte_ff == CHAR_CR) begin
            ph_c = PHASE_CR;
         end else begin
            err_c = 1'b1;
         end
      end
      if (in_last_ff && !err_c &&
          (ph_c inside {PHASE_START, PHASE_LEAD, PHASE_FIRST})) begin
         err_c = 1'b1;
      end
   end

   // result word
   assign emit = got || in_last_ff;
   assign out_data_in = {
      {PAD_BITS{1'b0}},
      err_c,
      FOUND_BITS'(count_c),
      sum_c,
      got ? RANGE_NUM_BITS'(count_ff) : {RANGE_NUM_BITS{1'b0}},
      got ? range_end : {FILE_SIZE_BITS{1'b0}},
      got ? range_start : {FILE_SIZE_BITS{1'b0}}
   };

   // next parser state; the last byte returns the parser to its reset state
   always_comb begin
      if (in_last_ff) begin
         phase_in  = PHASE_START;
         first_in  = '0;
         second_in = '0;
         dseen_in  = 2'b00;
         count_in  = '0;
         sum_in    = '0;
         err_in    = 1'b0;
      end else begin
         phase_in  = ph_c;
         first_in  = first_c;
         second_in = second_c;
         dseen_in  = dseen_c;
         count_in  = count_c;
         sum_in    = sum_c;
         err_in    = err_c;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         file_size_ff <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PHASE_START;
         first_ff     <= '0;
         second_ff    <= '0;
         dseen_ff     <= 2'b00;
         count_ff     <= '0;
         sum_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) file_size_ff <= csr_wr_data;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff  <= phase_in;
            first_ff  <= first_in;
            second_ff <= second_in;
            dseen_ff  <= dseen_in;
            count_ff  <= count_in;
            sum_ff    <= sum_in;
            err_ff    <= err_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
         out_last_ff <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: bench/byte_range_header_parser_core_tb.sv
// ----------------------------------------------------------------------------
// Byte range header parser - testbench
// Streams Range header values byte by byte into the core and scores every
// result word against a cycle-free model of the parser kept in the bench.
// A short scripted part covers the extreme bytes, each range form and the
// error paths. A randomised part follows over several file sizes, zero and
// the maximum among them, with random idling on both streams and two long
// result-side stalls.
// ----------------------------------------------------------------------------
module byte_range_header_parser_core_tb;
   import brhp_pkg::*;

   localparam int RANGE_LIMIT   = DEFAULT_MAX_RANGE_COUNT;
   localparam int OFFSET_WIDTH  = DEFAULT_OFFSET_BITS;
   localparam logic [63:0] OFFSET_MAX = (64'd1 << OFFSET_WIDTH) - 64'd1;
   localparam logic [63:0] TOTAL_MAX  = (64'd1 << SUM_BITS) - 64'd1;
   localparam logic [FILE_SIZE_BITS-1:0] SIZE_MAX = {FILE_SIZE_BITS{1'b1}};
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_BYTES   = 200;
   localparam int RANDOM_PHASES = 8;
   localparam int TIMEOUT_UNITS = 1_600_000;

   // one result word, split into its fields
   typedef struct {
      logic [FILE_SIZE_BITS-1:0] start_off;
      logic [FILE_SIZE_BITS-1:0] end_off;
      logic [RANGE_NUM_BITS-1:0] index;
      logic [SUM_BITS-1:0]       total;
      logic [FOUND_BITS-1:0]     found;
      logic                      flagged;
      logic                      closing;
   } range_report_type;

   typedef enum {ROW_SIZE, ROW_BYTE} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [FILE_SIZE_BITS-1:0] size;
      logic [BYTE_BITS-1:0]      c;
      bit                        last;
      bit                        typed;
      range_report_type          want;
   } script_row_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [BYTE_BITS-1:0]      req_tdata   = '0;
   logic                      req_tlast   = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_wr_en   = 1'b0;
   logic [FILE_SIZE_BITS-1:0] csr_wr_data = '0;

   byte_range_header_parser_core #(
      .MAX_RANGE_COUNT (RANGE_LIMIT),
      .OFFSET_BITS     (OFFSET_WIDTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // model state
   phase_type                 pr_phase;
   logic [63:0]               pr_first;
   logic [63:0]               pr_second;
   logic [1:0]                pr_digits;
   int unsigned               pr_count;
   logic [63:0]               pr_total;
   bit                        pr_bad;
   logic [FILE_SIZE_BITS-1:0] pr_size;
   bit                        pr_got;
   logic [63:0]               pr_got_start;
   logic [63:0]               pr_got_end;
   int unsigned               pr_got_index;

   range_report_type     awaited_reports[$];
   script_row_type       script[$];
   logic [BYTE_BITS-1:0] value_bytes[$];

   bit          hold_request = 1'b0;
   bit          send_calm    = 1'b0;
   bit          take_calm    = 1'b0;
   int unsigned fail_count   = 0;
   int unsigned bytes_sent   = 0;
   int unsigned values_sent  = 0;
   int unsigned ranges_made  = 0;
   int unsigned values_bad   = 0;
   int unsigned words_seen   = 0;
   int unsigned sizes_used   = 0;

   // ------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------
   function automatic bit blank_char(input logic [BYTE_BITS-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

   function automatic bit digit_char(input logic [BYTE_BITS-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic void clear_parser();
      pr_phase  = PHASE_START;
      pr_first  = '0;
      pr_second = '0;
      pr_digits = '0;
      pr_count  = 0;
      pr_total  = '0;
      pr_bad    = 1'b0;
   endfunction

   // decimal accumulate; an overflow flags the value and keeps the old number
   function automatic logic [63:0] shift_in_digit(input logic [63:0] value,
                                                  input logic [BYTE_BITS-1:0] c);
      logic [63:0] d;
      d = c - CHAR_ZERO;
      if (value > (OFFSET_MAX - d) / 64'd10) begin
         pr_bad = 1'b1;
         return value;
      end
      return value * 64'd10 + d;
   endfunction

   // check the pending range, then add it to the running total
   function automatic void close_range();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] fs;
      fs = pr_size;
      if (pr_phase == PHASE_SUFFIX) begin
         if (!pr_digits[1] || pr_second > fs) begin
            pr_bad = 1'b1;
            return;
         end
         lo = fs - pr_second;
         hi = fs;
      end else begin
         if (pr_first >= fs) begin
            pr_bad = 1'b1;
            return;
         end
         if (pr_digits[1]) begin
            if (pr_second > fs || pr_first >= pr_second) begin
               pr_bad = 1'b1;
               return;
            end
            hi = pr_second;
         end else begin
            hi = fs;
         end
         lo = pr_first;
      end
      pr_got       = 1'b1;
      pr_got_start = lo;
      pr_got_end   = hi;
      pr_got_index = pr_count;
      pr_count++;
      ranges_made++;
      if (pr_total > TOTAL_MAX - (hi - lo)) pr_total = TOTAL_MAX;
      else pr_total += hi - lo;
      pr_phase = PHASE_TRAIL;
   endfunction

   // blank, comma or CR after a range
   function automatic void end_of_range_byte(input logic [BYTE_BITS-1:0] c);
      if (!blank_char(c)) begin
         if (c == CHAR_COMMA) begin
            if (pr_count >= RANGE_LIMIT) begin
               pr_bad = 1'b1;
            end else begin
               pr_phase  = PHASE_LEAD;
               pr_first  = '0;
               pr_second = '0;
               pr_digits = '0;
            end
         end else if (c == CHAR_CR) begin
            pr_phase = PHASE_CR;
         end else begin
            pr_bad = 1'b1;
         end
      end
   endfunction

   function automatic void take_char(input logic [BYTE_BITS-1:0] c);
      case (pr_phase)
         PHASE_START, PHASE_LEAD: begin
            if (!(blank_char(c) && pr_phase == PHASE_LEAD)) begin
               if (digit_char(c)) begin
                  pr_first  = shift_in_digit(64'd0, c);
                  pr_digits = 2'b01;
                  pr_phase  = PHASE_FIRST;
               end else if (c == CHAR_DASH) begin
                  pr_second = '0;
                  pr_digits = '0;
                  pr_phase  = PHASE_SUFFIX;
               end else begin
                  pr_bad = 1'b1;
               end
            end
         end
         PHASE_FIRST: begin
            if (digit_char(c)) begin
               pr_first = shift_in_digit(pr_first, c);
            end else if (c == CHAR_DASH) begin
               pr_second = '0;
               pr_phase  = PHASE_SECOND;
            end else begin
               pr_bad = 1'b1;
            end
         end
         PHASE_SUFFIX, PHASE_SECOND: begin
            if (digit_char(c)) begin
               pr_second    = shift_in_digit(pr_second, c);
               pr_digits[1] = 1'b1;
            end else if (blank_char(c) || c == CHAR_COMMA || c == CHAR_CR) begin
               close_range();
               if (!pr_bad) end_of_range_byte(c);
            end else begin
               pr_bad = 1'b1;
            end
         end
         PHASE_TRAIL: end_of_range_byte(c);
         PHASE_CR: begin
            if (c == CHAR_LF) pr_phase = PHASE_DONE;
            else pr_bad = 1'b1;
         end
         default: pr_bad = 1'b1;
      endcase
   endfunction

   // one byte through the model; returns 1 when it yields a result word
   function automatic bit parse_byte(input logic [BYTE_BITS-1:0] c, input bit last,
                                     output range_report_type rpt);
      pr_got = 1'b0;
      if (!pr_bad) take_char(c);
      if (last && !pr_bad) begin
         if (pr_phase inside {PHASE_SUFFIX, PHASE_SECOND}) begin
            close_range();
         end else if (pr_phase inside {PHASE_START, PHASE_LEAD, PHASE_FIRST}) begin
            pr_bad = 1'b1;
         end
      end
      rpt.start_off = pr_got ? pr_got_start[FILE_SIZE_BITS-1:0] : '0;
      rpt.end_off   = pr_got ? pr_got_end[FILE_SIZE_BITS-1:0] : '0;
      rpt.index     = pr_got ? RANGE_NUM_BITS'(pr_got_index) : '0;
      rpt.total     = SUM_BITS'(pr_total);
      rpt.found     = FOUND_BITS'(pr_count);
      rpt.flagged   = pr_bad;
      rpt.closing   = last;
      if (last) begin
         values_sent++;
         if (pr_bad) values_bad++;
         clear_parser();
      end
      return last || pr_got;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic range_report_type final_word(input logic [SUM_BITS-1:0] total,
                                                   input logic [FOUND_BITS-1:0] found,
                                                   input logic flagged);
      range_report_type r;
      r.start_off = '0;
      r.end_off   = '0;
      r.index     = '0;
      r.total     = total;
      r.found     = found;
      r.flagged   = flagged;
      r.closing   = 1'b1;
      return r;
   endfunction

   function automatic void add_size(input logic [FILE_SIZE_BITS-1:0] v);
      script_row_type row;
      row.kind  = ROW_SIZE;
      row.size  = v;
      row.c     = '0;
      row.last  = 1'b0;
      row.typed = 1'b0;
      row.want  = final_word('0, '0, 1'b0);
      script.push_back(row);
   endfunction

   function automatic void add_byte(input logic [BYTE_BITS-1:0] c, input bit last);
      script_row_type row;
      row.kind  = ROW_BYTE;
      row.size  = '0;
      row.c     = c;
      row.last  = last;
      row.typed = 1'b0;
      row.want  = final_word('0, '0, 1'b0);
      script.push_back(row);
   endfunction

   // last byte of a value whose final word is known by inspection
   function automatic void add_check(input logic [BYTE_BITS-1:0] c,
                                     input range_report_type want);
      script_row_type row;
      row.kind  = ROW_BYTE;
      row.size  = '0;
      row.c     = c;
      row.last  = 1'b1;
      row.typed = 1'b1;
      row.want  = want;
      script.push_back(row);
   endfunction

   function automatic logic [BYTE_BITS-1:0] ascii_digit(input int n);
      return CHAR_ZERO + BYTE_BITS'(n);
   endfunction

   function automatic void append_blanks(input int n);
      repeat (n) value_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endfunction

   function automatic void append_number(input logic [63:0] v);
      logic [BYTE_BITS-1:0] digits[$];
      if ($urandom_range(0, 15) == 0) value_bytes.push_back(CHAR_ZERO);
      do begin
         digits.push_front(CHAR_ZERO + BYTE_BITS'(v % 64'd10));
         v = v / 64'd10;
      end while (v != 0);
      foreach (digits[k]) value_bytes.push_back(digits[k]);
   endfunction

   // offsets: mostly inside the file, plus the edges and overflowing numbers
   function automatic logic [63:0] pick_offset(input logic [FILE_SIZE_BITS-1:0] fs);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4: return r % ({16'd0, fs} + 64'd1);
         5, 6:          return 64'($urandom_range(0, 12));
         7:             return {16'd0, fs};
         8:             return {16'd0, fs} + 64'd1;
         9:             return {16'd0, fs} - 64'(fs != 0);
         10:            return $urandom_range(0, 1) ? (r & OFFSET_MAX)
                                                    : OFFSET_MAX + 64'($urandom_range(0, 1));
         default:       return r % 64'd100_000_000_000_000_000;
      endcase
   endfunction

   // one header value: mostly well-formed range lists, some broken on purpose
   function automatic void build_value(input logic [FILE_SIZE_BITS-1:0] fs);
      int          count;
      int          form;
      int          pick;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t;
      value_bytes.delete();
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
      for (int i = 0; i < count; i++) begin
         if (i > 0) begin
            value_bytes.push_back(CHAR_COMMA);
            if ($urandom_range(0, 2) == 0) append_blanks($urandom_range(1, 2));
         end else if ($urandom_range(0, 19) == 0) begin
            append_blanks(1);
         end
         pick = $urandom_range(0, 30);
         form = (pick == 0) ? 3 : pick % 3;
         a = pick_offset(fs);
         b = pick_offset(fs);
         if (a > b && $urandom_range(0, 4) != 0) begin
            t = a;
            a = b;
            b = t;
         end
         case (form)
            0: begin
               value_bytes.push_back(CHAR_DASH);
               if ($urandom_range(0, 24) != 0) append_number(b);
            end
            1: begin
               append_number(a);
               value_bytes.push_back(CHAR_DASH);
            end
            2: begin
               append_number(a);
               if ($urandom_range(0, 24) == 0) append_blanks(1);
               value_bytes.push_back(CHAR_DASH);
               append_number(b);
            end
            default: ;  // empty range
         endcase
         if ($urandom_range(0, 3) == 0) append_blanks($urandom_range(1, 2));
      end
      // line end: none, CR, CR LF, or stray bytes behind it
      case ($urandom_range(0, 7))
         4, 5: value_bytes.push_back(CHAR_CR);
         6: begin
            value_bytes.push_back(CHAR_CR);
            value_bytes.push_back(CHAR_LF);
         end
         7: begin
            value_bytes.push_back(CHAR_CR);
            if ($urandom_range(0, 1)) value_bytes.push_back(CHAR_LF);
            value_bytes.push_back(BYTE_BITS'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0 && value_bytes.size() != 0)
         value_bytes[$urandom_range(0, value_bytes.size() - 1)] =
            BYTE_BITS'($urandom_range(0, 255));
   endfunction

   // ------------------------------------------------------------------
   // request side driver; entered and left on a falling edge
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [BYTE_BITS-1:0] c, input bit last,
                            input bit typed, input range_report_type typed_want);
      int               gap;
      bit               yields;
      range_report_type rpt;
      if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      yields = parse_byte(c, last, rpt);
      if (typed) awaited_reports.push_back(typed_want);
      else if (yields) awaited_reports.push_back(rpt);
      bytes_sent++;
      @(negedge clock);
   endtask

   // block idle: nothing awaited and nothing left in flight
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (awaited_reports.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(input logic [FILE_SIZE_BITS-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      pr_size = v;
      sizes_used++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         fail_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // result side: random stalls, one long hold on request, scoring
   // ------------------------------------------------------------------
   initial begin : result_sink
      int               stall;
      range_report_type want;
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end else begin
            if ($urandom_range(0, 31) == 0) take_calm = !take_calm;
            stall = take_calm ? 0 : $urandom_range(0, 13);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         words_seen++;
         if (awaited_reports.size() == 0) begin
            $error("result word with nothing awaited: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = awaited_reports.pop_front();
            compare_field("range_start",  want.start_off, rsp_tdata[47:0]);
            compare_field("range_end",    want.end_off,   rsp_tdata[95:48]);
            compare_field("range_number", want.index,     rsp_tdata[98:96]);
            compare_field("total_length", want.total,     rsp_tdata[149:99]);
            compare_field("ranges_found", want.found,     rsp_tdata[153:150]);
            compare_field("parse_error",  want.flagged,   rsp_tdata[154]);
            compare_field("padding",      64'd0,          rsp_tdata[159:155]);
            compare_field("final_result", want.closing,   rsp_tlast);
         end
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [FILE_SIZE_BITS-1:0] size;
      clear_parser();
      pr_size = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // scripted part; file size still at its reset value of zero
      add_byte(CHAR_DASH, 1'b0);
      add_check(ascii_digit(0), final_word('0, 4'd1, 1'b0));    // empty suffix at end
      add_size(48'd1000);
      add_byte(ascii_digit(5), 1'b0);                           // closed range, comma
      add_byte(CHAR_DASH, 1'b0);
      add_byte(ascii_digit(9), 1'b0);
      add_byte(CHAR_COMMA, 1'b0);
      add_byte(CHAR_TAB, 1'b0);                                 // blank before suffix
      add_byte(CHAR_DASH, 1'b0);
      add_byte(ascii_digit(1), 1'b0);
      add_byte(CHAR_CR, 1'b0);
      add_byte(CHAR_LF, 1'b1);
      add_check(CHAR_SPACE, final_word('0, '0, 1'b1));          // blank before first range
      add_byte(ascii_digit(7), 1'b0);                           // blank before '-'
      add_byte(CHAR_SPACE, 1'b0);
      add_check(CHAR_DASH, final_word('0, '0, 1'b1));
      add_check(CHAR_DASH, final_word('0, '0, 1'b1));           // lone '-'
      add_byte(ascii_digit(3), 1'b0);                           // open range
      add_byte(CHAR_DASH, 1'b1);
      add_size(SIZE_MAX);
      add_check(8'hFF, final_word('0, '0, 1'b1));               // stray bytes
      add_check(8'h00, final_word('0, '0, 1'b1));
      add_byte(ascii_digit(0), 1'b0);                           // whole of largest file
      add_byte(CHAR_DASH, 1'b1);

      foreach (script[i]) begin
         if (script[i].kind == ROW_SIZE) begin
            wait_drained();
            write_size(script[i].size);
         end else begin
            send_byte(script[i].c, script[i].last, script[i].typed, script[i].want);
         end
      end

      // random part, one file size per phase
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         int unsigned phase_start;
         case (p)
            0:       size = '0;
            1:       size = 48'd1;
            2:       size = 48'($urandom_range(2, 60));
            3:       size = 48'($urandom_range(100, 5000));
            4:       size = 48'd1_000_000;
            5:       size = SIZE_MAX;
            6:       size = FILE_SIZE_BITS'({$urandom, $urandom});
            default: size = 48'($urandom_range(1, 100000));
         endcase
         wait_drained();
         write_size(size);
         if (p == 3 || p == 6) hold_request = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_value(pr_size);
            foreach (value_bytes[k])
               send_byte(value_bytes[k], k == value_bytes.size() - 1, 1'b0,
                         final_word('0, '0, 1'b0));
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Covered %0d bytes in %0d header values over %0d file sizes.",
               bytes_sent, values_sent, sizes_used);
      $display("%0d result words scored: %0d ranges, %0d values flagged malformed.",
               words_seen, ranges_made, values_bad);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(TIMEOUT_UNITS);
      $display("simulation failed");
      $finish;
   end

endmodule
